@@ rtl/gfa_pkg.sv @@
// ============================================================================
// gfa_pkg -- shared types, constants and microcode for the GF(2^m) unit
// Holds the field-constant derivation, the x-times step of the multiplier
// and the control-store program that sequences every operation.
// ============================================================================
package gfa_pkg;

   localparam int WORD_BITS   = 64;
   localparam int RESULT_BITS = 63;
   localparam int DIGIT_BITS  = 8;
   localparam int MUL_STEPS   = WORD_BITS / DIGIT_BITS;
   localparam int STEP_W      = $clog2(MUL_STEPS);
   localparam int PC_W        = 4;
   localparam int FUNC_W      = 2;

   typedef logic [WORD_BITS-1:0] word_type;

   // operation codes (req_tuser)
   localparam logic [FUNC_W-1:0] FUNC_REDUCE   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_MULTIPLY = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_POWER    = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_TRACE    = 2'd3;

   // micro-op kinds
   localparam logic [2:0] UOP_MUL   = 3'd0;  // run multiplier, write x
   localparam logic [2:0] UOP_PINIT = 3'd1;  // power setup
   localparam logic [2:0] UOP_TINIT = 3'd2;  // trace setup, skip if degree one
   localparam logic [2:0] UOP_EBIT  = 3'd3;  // pop exponent msb, skip multiply if zero
   localparam logic [2:0] UOP_LOOP  = 3'd4;  // count down, jump back while not done
   localparam logic [2:0] UOP_DONE  = 3'd5;  // post result

   // multiplier digit source
   localparam logic [1:0] BITS_X_RAW  = 2'd0;
   localparam logic [1:0] BITS_X_MASK = 2'd1;
   localparam logic [1:0] BITS_Y_MASK = 2'd2;

   // multiplier addend source (always masked to n bits)
   localparam logic [1:0] ADD_ONE = 2'd0;
   localparam logic [1:0] ADD_X   = 2'd1;
   localparam logic [1:0] ADD_Y   = 2'd2;

   // result source
   localparam logic [1:0] RES_X    = 2'd0;
   localparam logic [1:0] RES_SUM  = 2'd1;
   localparam logic [1:0] RES_ZERO = 2'd2;

   // program entry points
   localparam logic [PC_W-1:0] PC_REDUCE   = 4'd0;
   localparam logic [PC_W-1:0] PC_MULTIPLY = 4'd2;
   localparam logic [PC_W-1:0] PC_POWER    = 4'd4;
   localparam logic [PC_W-1:0] PC_TRACE    = 4'd10;
   localparam logic [PC_W-1:0] PC_NOFIELD  = 4'd14;

   localparam word_type RESET_MODULUS = 64'd19;

   typedef struct packed {
      logic [2:0]      kind;
      logic [1:0]      bits_sel;
      logic [1:0]      add_sel;
      logic            acc;
      logic [1:0]      res_sel;
      logic [PC_W-1:0] target;
   } uop_type;

   // modulus without its top term, low_mask(n), and bit n-1
   typedef struct packed {
      word_type red;
      word_type mask;
      word_type top;
   } field_type;

   typedef struct packed {
      logic     start;
      word_type bits;
      word_type addend;
   } mul_req_type;

   function automatic field_type field_from_modulus(input word_type m);
      word_type  s;
      field_type f;
      s = m;
      for (int k = 1; k < WORD_BITS; k = k * 2) begin
         s = s | (s >> k);
      end
      f.mask = s >> 1;
      f.top  = f.mask & ~(f.mask >> 1);
      f.red  = m & f.mask;
      return f;
   endfunction

   // v * x mod p, v below degree n
   function automatic word_type xtime(input word_type v, input field_type f);
      word_type r;
      r = (v << 1) & f.mask;
      if (|(v & f.top)) begin
         r = r ^ f.red;
      end
      return r;
   endfunction

   function automatic logic [PC_W-1:0] entry_pc(input logic [FUNC_W-1:0] func);
      logic [PC_W-1:0] pc;
      unique case (func)
         FUNC_REDUCE:   pc = PC_REDUCE;
         FUNC_MULTIPLY: pc = PC_MULTIPLY;
         FUNC_POWER:    pc = PC_POWER;
         FUNC_TRACE:    pc = PC_TRACE;
         default:       pc = PC_NOFIELD;
      endcase
      return pc;
   endfunction

   function automatic uop_type mk(input logic [2:0] kind, input logic [1:0] bs,
                                  input logic [1:0] as, input logic acc,
                                  input logic [1:0] rs, input logic [PC_W-1:0] tgt);
      uop_type u;
      u.kind     = kind;
      u.bits_sel = bs;
      u.add_sel  = as;
      u.acc      = acc;
      u.res_sel  = rs;
      u.target   = tgt;
      return u;
   endfunction

   // control store
   function automatic uop_type uop_rom(input logic [PC_W-1:0] pc);
      uop_type u;
      unique case (pc)
         // reduce: Horner over all 64 bits of a
         4'd0:  u = mk(UOP_MUL,   BITS_X_RAW,  ADD_ONE, 1'b0, RES_X,    4'd0);
         4'd1:  u = mk(UOP_DONE,  BITS_X_RAW,  ADD_ONE, 1'b0, RES_X,    4'd0);
         // multiply
         4'd2:  u = mk(UOP_MUL,   BITS_Y_MASK, ADD_X,   1'b0, RES_X,    4'd0);
         4'd3:  u = mk(UOP_DONE,  BITS_X_RAW,  ADD_ONE, 1'b0, RES_X,    4'd0);
         // power: left-to-right square and multiply
         4'd4:  u = mk(UOP_PINIT, BITS_X_RAW,  ADD_ONE, 1'b0, RES_X,    4'd0);
         4'd5:  u = mk(UOP_MUL,   BITS_X_MASK, ADD_X,   1'b0, RES_X,    4'd0);
         4'd6:  u = mk(UOP_EBIT,  BITS_X_RAW,  ADD_ONE, 1'b0, RES_X,    4'd8);
         4'd7:  u = mk(UOP_MUL,   BITS_X_MASK, ADD_Y,   1'b0, RES_X,    4'd0);
         4'd8:  u = mk(UOP_LOOP,  BITS_X_RAW,  ADD_ONE, 1'b0, RES_X,    4'd5);
         4'd9:  u = mk(UOP_DONE,  BITS_X_RAW,  ADD_ONE, 1'b0, RES_X,    4'd0);
         // trace: n-1 squarings, fold bit 0 of each term
         4'd10: u = mk(UOP_TINIT, BITS_X_RAW,  ADD_ONE, 1'b0, RES_SUM,  4'd13);
         4'd11: u = mk(UOP_MUL,   BITS_X_MASK, ADD_X,   1'b0, RES_SUM,  4'd0);
         4'd12: u = mk(UOP_LOOP,  BITS_X_RAW,  ADD_ONE, 1'b1, RES_SUM,  4'd11);
         4'd13: u = mk(UOP_DONE,  BITS_X_RAW,  ADD_ONE, 1'b0, RES_SUM,  4'd0);
         // modulus 0 or 1 (no field)
         4'd14: u = mk(UOP_DONE,  BITS_X_RAW,  ADD_ONE, 1'b0, RES_ZERO, 4'd0);
         default: u = mk(UOP_DONE, BITS_X_RAW, ADD_ONE, 1'b0, RES_ZERO, 4'd0);
      endcase
      return u;
   endfunction

endpackage

@@ rtl/gfa_mul.sv @@
// ============================================================================
// gfa_mul -- digit-serial modular multiplier over GF(2)[x]
// MSB-first Horner: acc = acc*x mod p + (bit ? addend : 0), one 8-bit digit
// of the multiplier word per cycle. Multiplying by one gives plain reduction.
// ============================================================================
module gfa_mul (
   input  logic                 clock,
   input  logic                 reset,
   input  gfa_pkg::field_type   field,
   input  gfa_pkg::mul_req_type req,
   output logic                 done,
   output gfa_pkg::word_type    product
);
   import gfa_pkg::*;

   logic              run_ff,  run_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   word_type          bits_ff, bits_in;
   word_type          acc_ff,  acc_in;
   word_type          digit_acc;

   always_comb begin
      digit_acc = acc_ff;
      for (int j = 0; j < DIGIT_BITS; j++) begin
         digit_acc = xtime(digit_acc, field);
         if (bits_ff[WORD_BITS-1-j]) begin
            digit_acc = digit_acc ^ req.addend;
         end
      end
   end

   always_comb begin
      run_in  = run_ff;
      step_in = step_ff;
      bits_in = bits_ff;
      acc_in  = acc_ff;
      done_in = 1'b0;
      if (req.start) begin
         run_in  = 1'b1;
         step_in = '0;
         bits_in = req.bits;
         acc_in  = '0;
      end else if (run_ff) begin
         acc_in  = digit_acc;
         bits_in = bits_ff << DIGIT_BITS;
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(MUL_STEPS - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      bits_ff <= bits_in;
      acc_ff  <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

@@ rtl/gf2m_field_arithmetic_top.sv @@
// ============================================================================
// gf2m_field_arithmetic_top -- GF(2^m) polynomial-basis arithmetic unit
// Reduce, multiply, power and trace modulo a programmable polynomial,
// sequenced by a small control store around one shared multiplier.
// ============================================================================
// One item is worked at a time; req_tready is low from acceptance until the
// result is loaded into the output register, which can hold one finished
// item while the next is accepted. Every multiply, square or reduction goes
// through the shared multiplier at one 8-bit digit per cycle. Power walks all
// 64 exponent bits (each exponent bit costs a square plus, if set, a
// multiply); trace takes n-1 squarings; a modulus of 0 or 1 answers 0.
// field_modulus is derived into field constants as it is written, so an
// item may follow a write directly.
module gf2m_field_arithmetic_top (
   input  logic                              clock,
   input  logic                              reset,
   // configuration
   input  logic                              csr_wr_en,
   input  gfa_pkg::word_type                 csr_wr_data,  // field_modulus
   // request
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [2*gfa_pkg::WORD_BITS-1:0]   req_tdata,    // operand_a, operand_b
   input  logic [gfa_pkg::FUNC_W-1:0]        req_tuser,    // func
   // response
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output gfa_pkg::word_type                 rsp_tdata     // result, zero pad
);
   import gfa_pkg::*;

   field_type         field_ff,    field_in;
   logic              field_ok_ff, field_ok_in;
   logic              active_ff,   active_in;
   logic              started_ff,  started_in;
   logic [PC_W-1:0]   pc_ff,       pc_in;
   word_type          x_ff,        x_in;
   word_type          y_ff,        y_in;
   word_type          e_ff,        e_in;
   word_type          cnt_ff,      cnt_in;
   logic              sum_ff,      sum_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [RESULT_BITS-1:0] rsp_data_ff, rsp_data_in;

   uop_type           uop;
   mul_req_type       mul_req;
   logic              mul_done;
   word_type          mul_product;
   logic              accept;
   logic [PC_W-1:0]   pc_next;

   gfa_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .field   (field_ff),
      .req     (mul_req),
      .done    (mul_done),
      .product (mul_product)
   );

   assign uop     = uop_rom(pc_ff);
   assign accept  = req_tvalid && req_tready;
   assign pc_next = pc_ff + 1'b1;

   // operand routing into the multiplier
   always_comb begin
      mul_req.start = 1'b0;
      case (uop.bits_sel)
         BITS_X_MASK: mul_req.bits = x_ff & field_ff.mask;
         BITS_Y_MASK: mul_req.bits = y_ff & field_ff.mask;
         default:     mul_req.bits = x_ff;
      endcase
      case (uop.add_sel)
         ADD_X:   mul_req.addend = x_ff & field_ff.mask;
         ADD_Y:   mul_req.addend = y_ff & field_ff.mask;
         default: mul_req.addend = word_type'(1) & field_ff.mask;
      endcase
      if (active_ff && uop.kind == UOP_MUL && !started_ff) begin
         mul_req.start = 1'b1;
      end
   end

   // sequencer
   always_comb begin
      field_in     = field_ff;
      field_ok_in  = field_ok_ff;
      active_in    = active_ff;
      started_in   = started_ff;
      pc_in        = pc_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      e_in         = e_ff;
      cnt_in       = cnt_ff;
      sum_in       = sum_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      if (csr_wr_en) begin
         field_in    = field_from_modulus(csr_wr_data);
         field_ok_in = |csr_wr_data[WORD_BITS-1:1];
      end

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      if (accept) begin
         x_in       = req_tdata[WORD_BITS-1:0];
         y_in       = req_tdata[2*WORD_BITS-1:WORD_BITS];
         sum_in     = req_tdata[0];
         pc_in      = field_ok_ff ? entry_pc(req_tuser) : PC_NOFIELD;
         active_in  = 1'b1;
         started_in = 1'b0;
      end else if (active_ff) begin
         unique case (uop.kind)
            UOP_MUL: begin
               if (!started_ff) begin
                  started_in = 1'b1;
               end else if (mul_done) begin
                  x_in       = mul_product;
                  started_in = 1'b0;
                  pc_in      = pc_next;
               end
            end
            UOP_PINIT: begin
               e_in   = y_ff;
               y_in   = x_ff;
               x_in   = word_type'(1);
               cnt_in = '1;
               pc_in  = pc_next;
            end
            UOP_TINIT: begin
               // mask >> 1 holds n-1 ones: one per squaring
               cnt_in = field_ff.mask >> 1;
               pc_in  = (|field_ff.mask[WORD_BITS-1:1]) ? pc_next : uop.target;
            end
            UOP_EBIT: begin
               e_in  = e_ff << 1;
               pc_in = e_ff[WORD_BITS-1] ? pc_next : uop.target;
            end
            UOP_LOOP: begin
               cnt_in = cnt_ff >> 1;
               if (uop.acc) begin
                  sum_in = sum_ff ^ x_ff[0];
               end
               pc_in = (|cnt_ff[WORD_BITS-1:1]) ? uop.target : pc_next;
            end
            UOP_DONE: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  rsp_valid_in = 1'b1;
                  case (uop.res_sel)
                     RES_X:   rsp_data_in = x_ff[RESULT_BITS-1:0];
                     RES_SUM: rsp_data_in = RESULT_BITS'(sum_ff);
                     default: rsp_data_in = '0;
                  endcase
                  active_in = 1'b0;
               end
            end
            default: active_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_ff     <= field_from_modulus(RESET_MODULUS);
         field_ok_ff  <= 1'b1;
         active_ff    <= 1'b0;
         started_ff   <= 1'b0;
         pc_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         field_ff     <= field_in;
         field_ok_ff  <= field_ok_in;
         active_ff    <= active_in;
         started_ff   <= started_in;
         pc_ff        <= pc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      x_ff        <= x_in;
      y_ff        <= y_in;
      e_ff        <= e_in;
      cnt_ff      <= cnt_in;
      sum_ff      <= sum_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = !active_ff;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_data_ff};

   // an accepted item holds off the next one
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("input taken again right after an accept");

   // multiplier results only land on a started multiply step
   a_mul_done_owner: assert property (@(posedge clock) disable iff (reset)
      mul_done |-> (active_ff && started_ff && uop.kind == UOP_MUL))
      else $error("multiplier finished with no multiply step waiting");

   // no arithmetic runs without a field
   a_mul_needs_field: assert property (@(posedge clock) disable iff (reset)
      mul_req.start |-> field_ok_ff)
      else $error("multiplier started for a modulus of degree zero");

endmodule

@@ dv/gf2m_field_checker.sv @@
// ----------------------------------------------------------------------------
// gf2m_field_checker -- result predictor and scoreboard for the GF(2^m) unit
// Follows field_modulus writes and accepted request items, works out the
// expected field element for each item, and compares every accepted
// response item against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module gf2m_field_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  gfa_pkg::word_type                   csr_wr_data,
   input  logic                                req_tvalid,
   input  logic                                req_tready,
   input  logic [2*gfa_pkg::WORD_BITS-1:0]     req_tdata,    // operand_a, operand_b
   input  logic [gfa_pkg::FUNC_W-1:0]          req_tuser,    // func
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  gfa_pkg::word_type                   rsp_tdata,    // result, zero pad
   output int                                  failures,
   output int                                  in_flight,
   output int                                  results_seen
);
   timeunit 1ns;
   timeprecision 1ps;

   import gfa_pkg::*;

   typedef logic [RESULT_BITS-1:0] element_type;

   typedef struct {
      logic [FUNC_W-1:0] func;
      word_type          operand_a;
      word_type          operand_b;
      element_type       element;
   } op_record_type;

   word_type      field_modulus;
   op_record_type element_q[$];

   function automatic int unsigned degree_of(input word_type v);
      int unsigned d;
      d = 0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (v[i]) d = i;
      end
      return d;
   endfunction

   function automatic word_type poly_remainder(input word_type a, input word_type m,
                                               input int unsigned n);
      word_type r;
      r = a;
      while (r != '0 && degree_of(r) >= n) begin
         r = r ^ (m << (degree_of(r) - n));
      end
      return r;
   endfunction

   // shift-and-add product, operands truncated to n bits
   function automatic word_type field_product(input word_type a, input word_type b,
                                              input word_type m, input int unsigned n);
      word_type mask;
      word_type red;
      word_type acc;
      word_type x;
      word_type y;
      logic     carry;
      mask = (word_type'(1) << n) - 1;
      red  = m & mask;
      x    = a & mask;
      y    = b & mask;
      acc  = '0;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (y == '0) break;
         if (y[0]) acc = acc ^ x;
         y     = y >> 1;
         carry = x[n-1];
         x     = (x << 1) & mask;
         if (carry) x = x ^ red;
      end
      return acc;
   endfunction

   // LSB-first square and multiply; zero exponent gives 1
   function automatic word_type field_power(input word_type base, input word_type e,
                                            input word_type m, input int unsigned n);
      word_type acc;
      word_type sq;
      word_type ex;
      acc = word_type'(1);
      sq  = base & ((word_type'(1) << n) - 1);
      ex  = e;
      for (int i = 0; i < WORD_BITS; i++) begin
         if (ex == '0) break;
         if (ex[0]) acc = field_product(acc, sq, m, n);
         sq = field_product(sq, sq, m, n);
         ex = ex >> 1;
      end
      return acc;
   endfunction

   function automatic word_type field_trace_bit(input word_type a, input word_type m,
                                                input int unsigned n);
      word_type sum;
      word_type term;
      sum  = a;
      term = a;
      for (int unsigned i = 1; i < n; i++) begin
         term = field_product(term, term, m, n);
         sum  = sum ^ term;
      end
      return sum & word_type'(1);
   endfunction

   function automatic element_type field_op_result(input logic [FUNC_W-1:0] func,
                                                   input word_type a, input word_type b,
                                                   input word_type m);
      word_type    r;
      int unsigned n;
      r = '0;
      // moduli 0 and 1 define no field: every operation answers 0
      if (m > word_type'(1)) begin
         n = degree_of(m);
         case (func)
            FUNC_REDUCE:   r = poly_remainder(a, m, n);
            FUNC_MULTIPLY: r = field_product(a, b, m, n);
            FUNC_POWER:    r = field_power(a, b, m, n);
            default:       r = field_trace_bit(a, m, n);
         endcase
      end
      return r[RESULT_BITS-1:0];
   endfunction

   always @(posedge clock) begin : scoreboard
      op_record_type rec;
      op_record_type want;
      if (reset) begin
         field_modulus = RESET_MODULUS;
         element_q.delete();
         failures      = 0;
         in_flight    <= 0;
         results_seen <= 0;
      end else begin
         // prediction uses the modulus in force before any write at this edge
         if (req_tvalid && req_tready) begin
            rec.func      = req_tuser;
            rec.operand_a = req_tdata[WORD_BITS-1:0];
            rec.operand_b = req_tdata[2*WORD_BITS-1:WORD_BITS];
            rec.element   = field_op_result(rec.func, rec.operand_a, rec.operand_b,
                                            field_modulus);
            element_q = {element_q, rec};
         end
         if (rsp_tvalid && rsp_tready) begin
            results_seen <= results_seen + 1;
            if (element_q.size() == 0) begin
               $display("%0t: unexpected result, expected none, got %h", $time,
                        rsp_tdata[RESULT_BITS-1:0]);
               failures++;
            end else begin
               want = element_q.pop_front();
               if (rsp_tdata[RESULT_BITS-1:0] !== want.element) begin
                  $display("%0t: func %0d a=%h b=%h: expected %h, got %h", $time,
                           want.func, want.operand_a, want.operand_b, want.element,
                           rsp_tdata[RESULT_BITS-1:0]);
                  failures++;
               end
            end
         end
         if (csr_wr_en) field_modulus = csr_wr_data;
         in_flight <= element_q.size();
      end
   end

endmodule

@@ dv/tb_gf2m_field_arithmetic_top.sv @@
// ----------------------------------------------------------------------------
// tb_gf2m_field_arithmetic_top -- stimulus and verdict for the GF(2^m) unit
// Directed corner items followed by random phases, each under a new
// field_modulus, with random idle gaps on both streams and one long
// response stall; the checker beside the block does all comparisons.
// ----------------------------------------------------------------------------
module tb_gf2m_field_arithmetic_top;
   timeunit 1ns;
   timeprecision 1ps;

   import gfa_pkg::*;

   localparam int CYCLE_LIMIT     = 6_000_000;
   localparam int DRAIN_CYCLES    = 1500;    // longer than a worst-case power
   localparam int LONG_HOLD       = 3000;
   localparam int HOLD_AFTER      = 60;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 84;
   localparam word_type ALL_ONES  = '1;

   logic                     clock;
   logic                     reset;
   logic                     csr_wr_en;
   word_type                 csr_wr_data;
   logic                     req_tvalid;
   logic                     req_tready;
   logic [2*WORD_BITS-1:0]   req_tdata;     // operand_a, operand_b
   logic [FUNC_W-1:0]        req_tuser;     // func
   logic                     rsp_tvalid;
   logic                     rsp_tready;
   word_type                 rsp_tdata;     // result, zero pad

   int failures;
   int in_flight;
   int results_seen;
   int op_count [4];
   int modulus_writes;
   int req_calm;
   int rsp_calm;
   int cycle_count;
   bit long_hold_done;

   word_type preset_moduli [6] = '{64'h11B, ALL_ONES, 64'h8000_0000_0000_0000,
                                   64'd3, 64'd0, RESET_MODULUS};

   gf2m_field_arithmetic_top dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata)
   );

   gf2m_field_checker field_check (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .failures     (failures),
      .in_flight    (in_flight),
      .results_seen (results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // mostly short gaps, a few long ones, and now and then a run with none
   function automatic int pick_gap(inout int calm);
      int roll;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
         calm = $urandom_range(20, 60);
         return 0;
      end
      if (roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic word_type rand_operand();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0:       return '0;
         1:       return ALL_ONES;
         2:       return word_type'($urandom_range(0, 15));
         3:       return word_type'(1) << $urandom_range(0, WORD_BITS - 1);
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic word_type rand_exponent();
      int roll;
      roll = $urandom_range(0, 9);
      case (roll)
         0:       return '0;
         1:       return word_type'(1);
         2:       return ALL_ONES;
         3:       return word_type'($urandom_range(2, 255));
         default: return {$urandom, $urandom};
      endcase
   endfunction

   function automatic word_type rand_modulus();
      int unsigned d;
      word_type    m;
      d = $urandom_range(1, WORD_BITS - 1);
      m = {$urandom, $urandom};
      if (d < WORD_BITS - 1) m = m & ((word_type'(1) << (d + 1)) - 1);
      m[d] = 1'b1;
      return m;
   endfunction

   task automatic send_item(input logic [FUNC_W-1:0] func, input word_type a,
                            input word_type b);
      int gap;
      gap = pick_gap(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {b, a};
      do @(posedge clock); while (!req_tready);
      op_count[func]++;
   endtask

   // block is idle once every predicted item has come back
   task automatic settle();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (in_flight != 0);
   endtask

   task automatic load_modulus(input word_type m);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= m;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      modulus_writes++;
   endtask

   initial begin : stimulus
      logic [FUNC_W-1:0] func;
      word_type          a;
      word_type          b;
      reset       <= 1'b1;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= '0;
      req_tvalid  <= 1'b0;
      req_tdata   <= '0;
      req_tuser   <= FUNC_REDUCE;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset modulus x^4+x+1
      send_item(FUNC_REDUCE,   '0,       '0);
      send_item(FUNC_REDUCE,   ALL_ONES, ALL_ONES);
      send_item(FUNC_REDUCE,   64'h8000_0000_0000_0000, '0);
      send_item(FUNC_MULTIPLY, ALL_ONES, ALL_ONES);
      send_item(FUNC_MULTIPLY, 64'h2,    64'h9);
      send_item(FUNC_POWER,    '0,       '0);
      send_item(FUNC_POWER,    ALL_ONES, '0);
      send_item(FUNC_POWER,    '0,       64'd5);
      send_item(FUNC_POWER,    ALL_ONES, ALL_ONES);
      send_item(FUNC_POWER,    64'h2,    64'd15);
      send_item(FUNC_TRACE,    '0,       '0);
      send_item(FUNC_TRACE,    ALL_ONES, ALL_ONES);
      send_item(FUNC_TRACE,    64'h1,    '0);

      // no field: everything answers zero
      settle();
      load_modulus(64'd0);
      send_item(FUNC_REDUCE,   ALL_ONES, ALL_ONES);
      send_item(FUNC_MULTIPLY, ALL_ONES, ALL_ONES);
      send_item(FUNC_POWER,    ALL_ONES, '0);
      send_item(FUNC_TRACE,    ALL_ONES, ALL_ONES);
      settle();
      load_modulus(64'd1);
      send_item(FUNC_POWER,    '0,       '0);
      send_item(FUNC_TRACE,    ALL_ONES, '0);

      // degree one: trace is bit 0 of a
      settle();
      load_modulus(64'd2);
      send_item(FUNC_TRACE,    64'h1,    '0);
      send_item(FUNC_TRACE,    ALL_ONES, '0);
      send_item(FUNC_MULTIPLY, ALL_ONES, ALL_ONES);
      send_item(FUNC_POWER,    ALL_ONES, ALL_ONES);
      settle();
      load_modulus(64'd3);
      send_item(FUNC_TRACE,    64'h2,    '0);
      send_item(FUNC_REDUCE,   ALL_ONES, '0);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         load_modulus(p < 6 ? preset_moduli[p] : rand_modulus());
         repeat (ITEMS_PER_PHASE) begin
            func = FUNC_W'($urandom_range(0, 3));
            a    = rand_operand();
            b    = (func == FUNC_POWER) ? rand_exponent() : rand_operand();
            send_item(func, a, b);
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d reduce, %0d multiply, %0d power and %0d trace items",
               op_count[FUNC_REDUCE], op_count[FUNC_MULTIPLY], op_count[FUNC_POWER],
               op_count[FUNC_TRACE]);
      $display("over %0d modulus writes (no-field, degree 1 and 63 among them), %0d results",
               modulus_writes, results_seen);
      if (failures == 0 && in_flight == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin : rsp_side
      int gap;
      rsp_tready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         // one long stall so the output register fills and req_tready drops
         if (!long_hold_done && results_seen >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         gap = pick_gap(rsp_calm);
         if (gap > 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ filelist.f @@
rtl/gfa_pkg.sv
rtl/gfa_mul.sv
rtl/gf2m_field_arithmetic_top.sv
dv/gf2m_field_checker.sv
dv/tb_gf2m_field_arithmetic_top.sv
